// ===== rtl/cfws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfws_pkg
// Shared constants and types for the circular FIFO with search: queue
// geometry, request opcodes, result status codes and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package cfws_pkg;

	// Queue geometry
	localparam int DEPTH  = 8;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int POS_W  = 3;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// Last slot index, for wrap of the circular pointers
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Controller to datapath commands
	typedef struct packed {
		logic                load;       // take a new request
		logic                ins_write;  // store data at the tail
		logic                pop;        // advance the head
		logic                adv;        // step the search walk
		logic                fin;        // load the result register
		logic [STAT_W-1:0]   fin_status;
		logic                fin_removed; // result carries read data
		logic                fin_found;   // result carries walk position
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            match;     // read entry equals request value
		logic            at_tail;   // walk index sits on the tail
		logic            out_free;  // result register can take a result
	} stat_t;

	// Wrapping increment of a slot index
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == LAST_IDX) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cfws_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/cfws_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfws_ctrl
// Request sequencer: accepts one request, decides insert/remove/search
// outcome from datapath status, steps the search walk and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module cfws_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire cfws_pkg::stat_t stat,
	output cfws_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_CMP  = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					cfws_pkg::OP_INSERT: begin
						if (stat.out_free) begin
							cmd.fin       = 1'b1;
							cmd.ins_write = !stat.full;
							cmd.fin_status = stat.full ? cfws_pkg::ST_FULL : cfws_pkg::ST_OK;
							state_d       = S_IDLE;
						end
					end
					cfws_pkg::OP_REMOVE, cfws_pkg::OP_SEARCH: begin
						if (!stat.empty) begin
							// first entry read is under way
							state_d = S_CMP;
						end else if (stat.out_free) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = cfws_pkg::ST_EMPTY;
							state_d        = S_IDLE;
						end
					end
					default: begin
						// unused opcode: plain ok result, no state change
						if (stat.out_free) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = cfws_pkg::ST_OK;
							state_d        = S_IDLE;
						end
					end
				endcase
			end
			S_CMP: begin
				if (stat.op == cfws_pkg::OP_REMOVE) begin
					if (stat.out_free) begin
						cmd.fin         = 1'b1;
						cmd.pop         = 1'b1;
						cmd.fin_removed = 1'b1;
						cmd.fin_status  = cfws_pkg::ST_OK;
						state_d         = S_IDLE;
					end
				end else if (stat.match) begin
					if (stat.out_free) begin
						cmd.fin        = 1'b1;
						cmd.fin_found  = 1'b1;
						cmd.fin_status = cfws_pkg::ST_OK;
						state_d        = S_IDLE;
					end
				end else if (stat.at_tail) begin
					if (stat.out_free) begin
						cmd.fin        = 1'b1;
						cmd.fin_status = cfws_pkg::ST_NOT_FOUND;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cfws_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfws_dp
// Datapath: entry RAM, head/tail pointers and empty flag, request latch,
// search walk index and position, and the result register.
// ----------------------------------------------------------------------------
module cfws_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [cfws_pkg::DATA_W-1:0]    s_tdata,
	input  wire logic [cfws_pkg::OP_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [39:0]                         m_tdata,
	output logic [cfws_pkg::STAT_W-1:0]         m_tuser,
	input  wire cfws_pkg::cmd_t                 cmd,
	output cfws_pkg::stat_t                     stat
);

	// Request latch
	logic [cfws_pkg::OP_W-1:0]          op_q;
	logic signed [cfws_pkg::DATA_W-1:0] val_q;

	// Queue pointers
	logic [cfws_pkg::IDX_W-1:0] head_q, tail_q;
	logic                       empty_q;

	// Walk state
	logic [cfws_pkg::IDX_W-1:0] idx_q, idx_next, rd_addr, wr_addr;
	logic [cfws_pkg::POS_W-1:0] pos_q;

	// Result register
	logic                               out_valid_q;
	logic [cfws_pkg::STAT_W-1:0]        status_q;
	logic signed [cfws_pkg::DATA_W-1:0] removed_q;
	logic [cfws_pkg::POS_W-1:0]         found_q;

	logic signed [cfws_pkg::DATA_W-1:0] rd_data;

	assign idx_next = cfws_pkg::next_slot(idx_q);
	// read address leads the walk index so data lines up with idx_q
	assign rd_addr  = cmd.adv ? idx_next : idx_q;
	assign wr_addr  = empty_q ? '0 : cfws_pkg::next_slot(tail_q);

	cfws_ram #(
		.WIDTH(cfws_pkg::DATA_W),
		.DEPTH(cfws_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ins_write),
		.waddr(wr_addr),
		.wdata(val_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Status to controller
	always_comb begin
		stat.op       = op_q;
		stat.empty    = empty_q;
		stat.full     = !empty_q && (cfws_pkg::next_slot(tail_q) == head_q);
		stat.match    = (rd_data == val_q);
		stat.at_tail  = (idx_q == tail_q);
		stat.out_free = !out_valid_q || m_tready;
	end

	// Request latch and walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser;
			val_q <= s_tdata;
			idx_q <= head_q;
			pos_q <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_next;
			pos_q <= pos_q + cfws_pkg::POS_W'(1);
		end
	end

	// Head, tail and empty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.ins_write) begin
			if (empty_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b0;
			end else begin
				tail_q <= wr_addr;
			end
		end else if (cmd.pop) begin
			if (head_q == tail_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else begin
				head_q <= cfws_pkg::next_slot(head_q);
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q  <= cmd.fin_status;
			removed_q <= cmd.fin_removed ? rd_data : '0;
			found_q   <= cmd.fin_found ? pos_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'b0, found_q, removed_q};

endmodule
`default_nettype wire

// ===== rtl/circular_fifo_with_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_with_search_core
// Circular FIFO of signed 32-bit words with insert, remove and search
// requests; one result per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time: a new request is accepted only after
// the result of the last one has been loaded into the result register. A
// search walks the queue from the head, reading one entry per cycle through
// the single RAM read port, until it finds a match or reaches the tail.
// Reset: queue empty, head and tail at slot 0, no result pending; the
// entry RAM is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_search_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] data_value
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] removed_value, [34:32] found_position
	output logic [1:0]       m_tuser    // [1:0] status
);

	cfws_pkg::cmd_t  cmd;
	cfws_pkg::stat_t stat;

	cfws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	cfws_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule
`default_nettype wire
